FILE: hw/rtl/lrfbs_pkg.sv
`timescale 1ns / 1ps

package lrfbs_pkg;

  localparam int unsigned CoordBitsDefault = 9;
  localparam int unsigned QueueDepth       = 2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgColorMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPanelWidth   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPanelHeight  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgColumnOffset = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRowOffset    = 3'd4;
  localparam int unsigned CfgDataW = 9;

  // color modes
  localparam logic [1:0] ModeRgb666 = 2'd0;
  localparam logic [1:0] ModeRgb565 = 2'd1;
  localparam logic [1:0] ModeRgb444 = 2'd2;

  localparam logic [8:0] PanelWidthReset  = 9'd128;
  localparam logic [8:0] PanelHeightReset = 9'd160;

  // panel command bytes
  localparam logic [7:0] CmdCaset = 8'h2a;
  localparam logic [7:0] CmdRaset = 8'h2b;
  localparam logic [7:0] CmdRamwr = 8'h2c;
  localparam logic [7:0] CmdNop   = 8'h00;

  // input item modes
  localparam logic ModeRequest = 1'b0;
  localparam logic ModeTick    = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [8:0] col_a;
    logic [8:0] row_a;
    logic [8:0] col_b;
    logic [8:0] row_b;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       frame_end;
    logic       fill_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0] color_mode;
    logic [8:0] panel_width;
    logic [8:0] panel_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

endpackage

FILE: hw/rtl/lrfbs_front.sv
`timescale 1ns / 1ps

module lrfbs_front #(
  parameter int unsigned CoordBits = lrfbs_pkg::CoordBitsDefault,
  parameter int unsigned EntryW    = 1 + 4 * CoordBits + 24
) (
  input  lrfbs_pkg::cfg_t     cfg_i,
  input  lrfbs_pkg::in_item_t in_data_i,
  output logic [EntryW-1:0]   entry_o
);

  localparam int unsigned CmpW = (CoordBits > 9) ? CoordBits : 9;

  typedef struct packed {
    logic                 tick;
    logic [CoordBits-1:0] col_lo;
    logic [CoordBits-1:0] col_hi;
    logic [CoordBits-1:0] row_lo;
    logic [CoordBits-1:0] row_hi;
    logic [7:0]           pix0;
    logic [7:0]           pix1;
    logic [7:0]           pix2;
  } entry_t;

  logic [CoordBits-1:0] x1, x2, y1, y2;
  logic [CoordBits-1:0] xs_lo, xs_hi, ys_lo, ys_hi;
  logic [8:0]           w_last, h_last;
  logic [7:0]           r, g, b;
  entry_t               ent;

  always_comb begin
    x1 = CoordBits'(in_data_i.col_a);
    y1 = CoordBits'(in_data_i.row_a);
    x2 = CoordBits'(in_data_i.col_b);
    y2 = CoordBits'(in_data_i.row_b);

    // put corners in order
    xs_lo = (x1 > x2) ? x2 : x1;
    xs_hi = (x1 > x2) ? x1 : x2;
    ys_lo = (y1 > y2) ? y2 : y1;
    ys_hi = (y1 > y2) ? y1 : y2;

    // zero panel size counts as one
    w_last = (cfg_i.panel_width == 9'd0) ? 9'd0 : cfg_i.panel_width - 9'd1;
    h_last = (cfg_i.panel_height == 9'd0) ? 9'd0 : cfg_i.panel_height - 9'd1;
    if (CmpW'(xs_hi) > CmpW'(w_last)) begin
      xs_hi = CoordBits'(w_last);
    end
    if (CmpW'(ys_hi) > CmpW'(h_last)) begin
      ys_hi = CoordBits'(h_last);
    end

    r = in_data_i.red;
    g = in_data_i.green;
    b = in_data_i.blue;

    ent.tick   = (in_data_i.mode == lrfbs_pkg::ModeTick);
    ent.col_lo = xs_lo;
    ent.col_hi = xs_hi;
    ent.row_lo = ys_lo;
    ent.row_hi = ys_hi;
    unique case (cfg_i.color_mode)
      lrfbs_pkg::ModeRgb565: begin
        ent.pix0 = {r[7:3], g[7:5]};
        ent.pix1 = {g[4:2], b[7:3]};
        ent.pix2 = 8'hff;
      end
      lrfbs_pkg::ModeRgb444: begin
        ent.pix0 = {r[7:4], g[7:4]};
        ent.pix1 = {b[7:4], r[7:4]};
        ent.pix2 = {g[7:4], b[7:4]};
      end
      default: begin
        ent.pix0 = {r[7:2], 2'b00};
        ent.pix1 = {g[7:2], 2'b00};
        ent.pix2 = {b[7:2], 2'b00};
      end
    endcase
  end

  assign entry_o = EntryW'(ent);

endmodule

FILE: hw/rtl/lrfbs_fifo.sv
`timescale 1ns / 1ps

module lrfbs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lrfbs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/lrfbs_back.sv
`timescale 1ns / 1ps

module lrfbs_back #(
  parameter int unsigned CoordBits = lrfbs_pkg::CoordBitsDefault,
  parameter int unsigned EntryW    = 1 + 4 * CoordBits + 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrfbs_pkg::cfg_t      cfg_i,
  input  logic                 entry_valid_i,
  input  logic [EntryW-1:0]    entry_i,
  output logic                 entry_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lrfbs_pkg::out_item_t out_data_o
);

  typedef struct packed {
    logic                 tick;
    logic [CoordBits-1:0] col_lo;
    logic [CoordBits-1:0] col_hi;
    logic [CoordBits-1:0] row_lo;
    logic [CoordBits-1:0] row_hi;
    logic [7:0]           pix0;
    logic [7:0]           pix1;
    logic [7:0]           pix2;
  } entry_t;

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhCaset  = 4'd1;
  localparam logic [3:0] PhCwords = 4'd2;
  localparam logic [3:0] PhRaset  = 4'd3;
  localparam logic [3:0] PhRwords = 4'd4;
  localparam logic [3:0] PhNop1   = 4'd5;
  localparam logic [3:0] PhRamwr  = 4'd6;
  localparam logic [3:0] PhPixels = 4'd7;
  localparam logic [3:0] PhNop2   = 4'd8;

  entry_t ent;

  logic [3:0]           phase_q, phase_d;
  logic [2:0]           step_q, step_d, step_inc, bpp;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [CoordBits-1:0] col_lo_q, col_hi_q, row_lo_q, row_hi_q;
  logic [7:0]           pix0_q, pix1_q, pix2_q, pix_byte;
  logic                 load;
  logic                 out_valid_q, out_valid_d;
  lrfbs_pkg::out_item_t out_q, out_d;
  logic [15:0]          cword, rword;
  logic [7:0]           cbyte, rbyte;

  function automatic lrfbs_pkg::out_item_t mk_out(logic [7:0] b, logic d, logic fe, logic fd);
    lrfbs_pkg::out_item_t o;
    o.link_byte = b;
    o.is_data   = d;
    o.frame_end = fe;
    o.fill_done = fd;
    return o;
  endfunction

  assign ent = entry_t'(entry_i);

  // window words with the controller offset added, high byte first
  assign cword = 16'(step_q[1] ? col_hi_q : col_lo_q) + 16'(cfg_i.column_offset);
  assign rword = 16'(step_q[1] ? row_hi_q : row_lo_q) + 16'(cfg_i.row_offset);
  assign cbyte = step_q[0] ? cword[7:0] : cword[15:8];
  assign rbyte = step_q[0] ? rword[7:0] : rword[15:8];

  assign step_inc = step_q + 3'd1;
  assign bpp      = (cfg_i.color_mode == lrfbs_pkg::ModeRgb565) ? 3'd2 : 3'd3;
  assign pix_byte = (step_q == 3'd0) ? pix0_q : (step_q == 3'd1) ? pix1_q : pix2_q;

  assign entry_pop_o = entry_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    col_d       = col_q;
    row_d       = row_q;
    load        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (entry_pop_o) begin
      if (!ent.tick) begin
        // a request while busy is dropped
        if (phase_q == PhIdle) begin
          load    = 1'b1;
          step_d  = 3'd0;
          col_d   = ent.col_lo;
          row_d   = ent.row_lo;
          phase_d = PhCaset;
        end
      end else begin
        unique case (phase_q)
          PhCaset: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(lrfbs_pkg::CmdCaset, 1'b0, 1'b0, 1'b0);
            step_d      = 3'd0;
            phase_d     = PhCwords;
          end
          PhCwords: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(cbyte, 1'b1, 1'b0, 1'b0);
            step_d      = step_inc;
            if (step_inc >= 3'd4) begin
              step_d  = 3'd0;
              phase_d = PhRaset;
            end
          end
          PhRaset: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(lrfbs_pkg::CmdRaset, 1'b0, 1'b0, 1'b0);
            step_d      = 3'd0;
            phase_d     = PhRwords;
          end
          PhRwords: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(rbyte, 1'b1, 1'b0, 1'b0);
            step_d      = step_inc;
            if (step_inc >= 3'd4) begin
              step_d  = 3'd0;
              phase_d = PhNop1;
            end
          end
          PhNop1: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(lrfbs_pkg::CmdNop, 1'b0, 1'b1, 1'b0);
            phase_d     = PhRamwr;
          end
          PhRamwr: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(lrfbs_pkg::CmdRamwr, 1'b0, 1'b0, 1'b0);
            step_d      = 3'd0;
            col_d       = col_lo_q;
            row_d       = row_lo_q;
            // empty window skips straight to the closing no-op
            if (col_lo_q > col_hi_q || row_lo_q > row_hi_q) begin
              phase_d = PhNop2;
            end else begin
              phase_d = PhPixels;
            end
          end
          PhPixels: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(pix_byte, 1'b1, 1'b0, 1'b0);
            step_d      = step_inc;
            if (step_inc >= bpp) begin
              step_d = 3'd0;
              if (col_q >= col_hi_q) begin
                col_d = col_lo_q;
                if (row_q >= row_hi_q) begin
                  phase_d = PhNop2;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
              end
            end
          end
          PhNop2: begin
            out_valid_d = 1'b1;
            out_d       = mk_out(lrfbs_pkg::CmdNop, 1'b0, 1'b1, 1'b1);
            step_d      = 3'd0;
            phase_d     = PhIdle;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      step_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) begin
      col_lo_q <= ent.col_lo;
      col_hi_q <= ent.col_hi;
      row_lo_q <= ent.row_lo;
      row_hi_q <= ent.row_hi;
      pix0_q   <= ent.pix0;
      pix1_q   <= ent.pix1;
      pix2_q   <= ent.pix2;
    end
  end

endmodule

FILE: hw/rtl/lcd_rect_fill_byte_sequencer_top.sv
`timescale 1ns / 1ps

// Rectangle fill byte sequencer for a serial TFT panel. A fill request (mode 0) orders the
// corners, clips the far column and row to the panel size and packs the color; each later
// tick (mode 1) yields one link byte with its data/command flag: column and row window
// words closed by a no-op, then memory-write, the pixel bytes and a closing no-op flagged
// fill_done. Requests while a fill runs and ticks while idle produce nothing. One item is
// taken per clock while the queue has room: the front end classifies and precomputes into
// a two-entry queue, the sequencer pops one entry per cycle into a single output register,
// so a byte appears in the cycle after its tick is popped and an output stall only backs
// up the queue. Configuration is a register write and is expected only while idle.
module lcd_rect_fill_byte_sequencer_top #(
  parameter int unsigned CoordBits = lrfbs_pkg::CoordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lrfbs_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lrfbs_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrfbs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lrfbs_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned EntryW = 1 + 4 * CoordBits + 24;

  lrfbs_pkg::cfg_t   cfg_q, cfg_d;
  logic [EntryW-1:0] push_entry, pop_entry;
  logic              q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lrfbs_pkg::CfgColorMode:    cfg_d.color_mode    = cfg_data_i[1:0];
        lrfbs_pkg::CfgPanelWidth:   cfg_d.panel_width   = cfg_data_i[8:0];
        lrfbs_pkg::CfgPanelHeight:  cfg_d.panel_height  = cfg_data_i[8:0];
        lrfbs_pkg::CfgColumnOffset: cfg_d.column_offset = cfg_data_i[7:0];
        lrfbs_pkg::CfgRowOffset:    cfg_d.row_offset    = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode    <= lrfbs_pkg::ModeRgb666;
      cfg_q.panel_width   <= lrfbs_pkg::PanelWidthReset;
      cfg_q.panel_height  <= lrfbs_pkg::PanelHeightReset;
      cfg_q.column_offset <= '0;
      cfg_q.row_offset    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !q_full;

  lrfbs_front #(
    .CoordBits (CoordBits),
    .EntryW    (EntryW)
  ) u_front (
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .entry_o   (push_entry)
  );

  lrfbs_fifo #(
    .Width (EntryW),
    .Depth (lrfbs_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  lrfbs_back #(
    .CoordBits (CoordBits),
    .EntryW    (EntryW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_valid_i (q_valid),
    .entry_i       (pop_entry),
    .entry_pop_o   (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

FILE: hw/rtl/lrfbs_checker.sv
`timescale 1ns / 1ps

module lrfbs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input lrfbs_pkg::out_item_t out_data_o
);

  // a stalled output transfer keeps its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // end of fill is always the closing no-op of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fill_done |->
      out_data_o.frame_end && !out_data_o.is_data &&
      out_data_o.link_byte == lrfbs_pkg::CmdNop)
    else $error("fill_done on a byte other than the closing no-op");

  // command bytes are limited to the window, write and no-op commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_data |->
      out_data_o.link_byte == lrfbs_pkg::CmdCaset ||
      out_data_o.link_byte == lrfbs_pkg::CmdRaset ||
      out_data_o.link_byte == lrfbs_pkg::CmdRamwr ||
      out_data_o.link_byte == lrfbs_pkg::CmdNop)
    else $error("unexpected command byte");

  // frame end only on a no-op command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |->
      !out_data_o.is_data && out_data_o.link_byte == lrfbs_pkg::CmdNop)
    else $error("frame_end on a byte other than a no-op");

endmodule

bind lcd_rect_fill_byte_sequencer_top lrfbs_checker u_lrfbs_checker (.*);
